// ===== design/hvd_pkg.sv =====
`default_nettype none

package hvd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;

    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 25;

    // angle words entering the sin/cos units, in units of 2^-(ANGLE_FRAC_BITS+1) degree
    localparam int ANG_W = LON_W + 1;
    localparam int R_W   = ((ANG_W > ANGLE_FRAC_BITS + 10) ? ANG_W : ANGLE_FRAC_BITS + 10) + 2;
    localparam longint TURN         = longint'(360) << (ANGLE_FRAC_BITS + 1);
    localparam longint HALF_TURN    = TURN / 2;
    localparam longint QUARTER_TURN = TURN / 4;

    localparam int MAG_W      = ANGLE_FRAC_BITS + 8;
    localparam int NORM_BITS  = 25;
    localparam int NORM_SHIFT = NORM_BITS - (ANGLE_FRAC_BITS + 1);
    localparam int SCL_W      = MAG_W + NORM_SHIFT;
    localparam longint DEG_TO_RAD_Q32 = 74961321;
    localparam int DRAD_W     = 27;
    localparam int RAD_SHIFT  = 27;
    localparam int PROD_W     = SCL_W + DRAD_W;
    localparam int ZMAG_W     = PROD_W - RAD_SHIFT;

    localparam int Q_FRAC = 30;
    localparam int Q_W    = 33;
    localparam longint ONE_Q30 = longint'(1) << Q_FRAC;

    localparam int CORDIC_STEPS = 30;
    localparam longint CORDIC_START = 652032874;

    localparam int H_W       = Q_FRAC + 1;
    localparam int SQ_OUT_W  = 31;
    localparam int SQ_IN_W   = 2 * SQ_OUT_W;
    localparam int ATAN_O_W  = 31;

    localparam longint EARTH_RADIUS_M = 6371000;
    localparam longint DIST_SCALE     = 2 * EARTH_RADIUS_M;
    localparam int DSCL_W     = 24;
    localparam int D_PROD_W   = ATAN_O_W + DSCL_W;
    localparam longint DIST_MAX = 20015087;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic signed [R_W-1:0] t_r;

    function automatic t_q atan_q30(input int k);
        t_q v;
        case (k)
            0:  v = t_q'(843314857);
            1:  v = t_q'(497837829);
            2:  v = t_q'(263043837);
            3:  v = t_q'(133525159);
            4:  v = t_q'(67021687);
            5:  v = t_q'(33543516);
            6:  v = t_q'(16775851);
            7:  v = t_q'(8388437);
            8:  v = t_q'(4194283);
            9:  v = t_q'(2097141);
            10: v = t_q'(1048574);
            11: v = t_q'(524287);
            12: v = t_q'(262143);
            13: v = t_q'(131071);
            14: v = t_q'(65535);
            15: v = t_q'(32767);
            16: v = t_q'(16383);
            17: v = t_q'(8191);
            18: v = t_q'(4095);
            19: v = t_q'(2047);
            20: v = t_q'(1023);
            21: v = t_q'(511);
            22: v = t_q'(255);
            23: v = t_q'(127);
            24: v = t_q'(63);
            25: v = t_q'(31);
            26: v = t_q'(15);
            27: v = t_q'(8);
            28: v = t_q'(4);
            29: v = t_q'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // q30 product, magnitude rounded half away from zero
    function automatic t_q mul_q30(input t_q a, input t_q b);
        logic                 neg;
        logic [Q_W-1:0]       ua;
        logic [Q_W-1:0]       ub;
        logic [2*Q_W-1:0]     p;
        logic [2*Q_W-1:0]     r;
        neg = a[Q_W-1] ^ b[Q_W-1];
        ua  = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
        ub  = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
        p   = (2*Q_W)'(ua) * (2*Q_W)'(ub);
        r   = (p + ((2*Q_W)'(1) << (Q_FRAC - 1))) >> Q_FRAC;
        return neg ? -t_q'(r[Q_W-1:0]) : t_q'(r[Q_W-1:0]);
    endfunction

    function automatic logic [SQ_IN_W-1:0] sq_bit(input int k);
        return SQ_IN_W'(1) << (2 * (SQ_OUT_W - 1 - k));
    endfunction

endpackage

`default_nettype wire

// ===== design/hvd_in_if.sv =====
`default_nettype none

interface hvd_in_if import hvd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_first;
    logic signed [LON_W-1:0] lon_first;
    logic signed [LAT_W-1:0] lat_second;
    logic signed [LON_W-1:0] lon_second;

    modport source (output valid, lat_first, lon_first, lat_second, lon_second, input ready);
    modport sink   (input valid, lat_first, lon_first, lat_second, lon_second, output ready);
endinterface

`default_nettype wire

// ===== design/hvd_out_if.sv =====
`default_nettype none

interface hvd_out_if import hvd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

`default_nettype wire

// ===== design/haversine_distance_core.sv =====
// channel   dir  transaction                                      payload
// i_in      in   i_in.valid & i_in.ready at rising i_clk        two points, lat/lon
// o_out     out  o_out.valid & o_out.ready at rising i_clk      distance_m
//
// one point pair per cycle while the pipeline is not held; each result passes through
// a 30-step cordic rotation, a 31-stage square root and a 30-step cordic
// vectoring in series
// i_rst_n is synchronous, clears the valid bits of every stage and holds i_in.ready low
// the whole pipeline advances together; it holds while o_out.valid is high and
// o_out.ready low, and outside reset i_in.ready is low for exactly those cycles
`default_nettype none

module haversine_distance_core import hvd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hvd_in_if.sink      i_in,
    hvd_out_if.source   o_out
);

    logic en;

    logic signed [ANG_W-1:0] dlat;
    logic signed [ANG_W-1:0] dlon;
    logic signed [ANG_W-1:0] lat1_x2;
    logic signed [ANG_W-1:0] lat2_x2;

    logic sc_valid;
    t_q   u;
    t_q   v;
    t_q   c1;
    t_q   c2;

    t_q   r_uu;
    t_q   r_vv;
    t_q   r_cc;
    logic r_vm1;
    t_q   r_uu2;
    t_q   r_p;
    logic r_vm2;
    logic [H_W-1:0] r_h;
    logic r_vh;
    logic [H_W-1:0] n_h;

    logic [SQ_IN_W-1:0]  rad_s;
    logic [SQ_IN_W-1:0]  rad_w;
    logic                sq_valid;
    logic [SQ_OUT_W-1:0] root_s;
    logic [SQ_OUT_W-1:0] root_w;

    logic                at_valid;
    logic [ATAN_O_W-1:0] ang;

    logic [D_PROD_W-1:0] r_dprod;
    logic                r_vd;
    logic [DIST_W-1:0]   r_dist;
    logic                r_out_valid;
    logic [DIST_W-1:0]   n_dist;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    assign dlat    = ANG_W'(i_in.lat_second) - ANG_W'(i_in.lat_first);
    assign dlon    = ANG_W'(i_in.lon_second) - ANG_W'(i_in.lon_first);
    assign lat1_x2 = ANG_W'(i_in.lat_first) <<< 1;
    assign lat2_x2 = ANG_W'(i_in.lat_second) <<< 1;

    hvd_sincos u_sc_dlat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_ang   (dlat),
        .o_valid (sc_valid),
        .o_sin   (u),
        .o_cos   ()
    );

    hvd_sincos u_sc_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_ang   (dlon),
        .o_valid (),
        .o_sin   (v),
        .o_cos   ()
    );

    hvd_sincos u_sc_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_ang   (lat1_x2),
        .o_valid (),
        .o_sin   (),
        .o_cos   (c1)
    );

    hvd_sincos u_sc_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_ang   (lat2_x2),
        .o_valid (),
        .o_sin   (),
        .o_cos   (c2)
    );

    // h = u^2 + c1*c2*v^2, clamped to 0..1
    always_comb begin
        logic signed [Q_W:0] sum;
        sum = (Q_W+1)'(r_uu2) + (Q_W+1)'(r_p);
        if (sum < 0) begin
            n_h = '0;
        end else if (sum > (Q_W+1)'(ONE_Q30)) begin
            n_h = H_W'(ONE_Q30);
        end else begin
            n_h = sum[H_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_uu  <= mul_q30(u, u);
            r_vv  <= mul_q30(v, v);
            r_cc  <= mul_q30(c1, c2);
            r_uu2 <= r_uu;
            r_p   <= mul_q30(r_cc, r_vv);
            r_h   <= n_h;
        end
    end

    assign rad_s = SQ_IN_W'(r_h) << Q_FRAC;
    assign rad_w = SQ_IN_W'(H_W'(ONE_Q30) - r_h) << Q_FRAC;

    hvd_isqrt u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vh),
        .i_rad   (rad_s),
        .o_valid (sq_valid),
        .o_root  (root_s)
    );

    hvd_isqrt u_sqrt_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vh),
        .i_rad   (rad_w),
        .o_valid (),
        .o_root  (root_w)
    );

    hvd_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_x     (t_q'(root_w)),
        .i_y     (t_q'(root_s)),
        .o_valid (at_valid),
        .o_ang   (ang)
    );

    // meters = angle * 2R, rounded, held at half the circumference
    always_comb begin
        logic [D_PROD_W:0]          rnd;
        logic [D_PROD_W-Q_FRAC:0]   d;
        rnd = (D_PROD_W+1)'(r_dprod) + ((D_PROD_W+1)'(1) << (Q_FRAC - 1));
        d   = rnd[D_PROD_W:Q_FRAC];
        if (d > (D_PROD_W-Q_FRAC+1)'(DIST_MAX)) begin
            n_dist = DIST_W'(DIST_MAX);
        end else begin
            n_dist = d[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dprod <= D_PROD_W'(ang) * D_PROD_W'(DIST_SCALE);
            r_dist  <= n_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1       <= 1'b0;
            r_vm2       <= 1'b0;
            r_vh        <= 1'b0;
            r_vd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vm1       <= sc_valid;
            r_vm2       <= r_vm1;
            r_vh        <= r_vm2;
            r_vd        <= at_valid;
            r_out_valid <= r_vd;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.distance_m = r_dist;

endmodule

`default_nettype wire

// ===== design/hvd_sincos.sv =====
`default_nettype none

module hvd_sincos import hvd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic signed [ANG_W-1:0] i_ang,
    output logic                         o_valid,
    output t_q                           o_sin,
    output t_q                           o_cos
);

    localparam t_r TURN_R    = t_r'(TURN);
    localparam t_r HALF_R    = t_r'(HALF_TURN);
    localparam t_r QUARTER_R = t_r'(QUARTER_TURN);

    logic [MAG_W-1:0]  r_mag;
    logic              r_neg0;
    logic              r_flip0;
    logic              r_v0;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg1;
    logic              r_flip1;
    logic              r_v1;

    t_q   r_x [0:CORDIC_STEPS];
    t_q   r_y [0:CORDIC_STEPS];
    t_q   r_z [0:CORDIC_STEPS];
    logic r_f [0:CORDIC_STEPS];
    logic r_v [0:CORDIC_STEPS];

    logic [MAG_W-1:0]  n_mag;
    logic              n_neg;
    logic              n_flip;
    logic [PROD_W-1:0] n_prod;
    t_q                n_z;

    // reduce into one turn around zero, fold into +-90 degrees
    always_comb begin
        t_r a;
        t_r r;
        a      = t_r'(i_ang);
        r      = a;
        n_flip = 1'b0;
        if (a >= HALF_R) begin
            r = a - TURN_R;
        end else if (a < -HALF_R) begin
            r = a + TURN_R;
        end
        if (r > QUARTER_R) begin
            r      = HALF_R - r;
            n_flip = 1'b1;
        end else if (r < -QUARTER_R) begin
            r      = -HALF_R - r;
            n_flip = 1'b1;
        end
        n_neg = r[R_W-1];
        n_mag = r[R_W-1] ? MAG_W'(-r) : MAG_W'(r);
    end

    assign n_prod = PROD_W'(SCL_W'(r_mag) << NORM_SHIFT) * PROD_W'(DEG_TO_RAD_Q32);

    always_comb begin
        logic [PROD_W-1:0] rnd;
        logic [ZMAG_W-1:0] zmag;
        rnd  = r_prod + (PROD_W'(1) << (RAD_SHIFT - 1));
        zmag = rnd[PROD_W-1:RAD_SHIFT];
        n_z  = r_neg1 ? -t_q'(zmag) : t_q'(zmag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= n_mag;
            r_neg0  <= n_neg;
            r_flip0 <= n_flip;
            r_prod  <= n_prod;
            r_neg1  <= r_neg0;
            r_flip1 <= r_flip0;
            r_x[0]  <= t_q'(CORDIC_START);
            r_y[0]  <= '0;
            r_z[0]  <= n_z;
            r_f[0]  <= r_flip1;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q30(k);
                end
                r_f[k+1] <= r_f[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v0   <= i_valid;
            r_v1   <= r_v0;
            r_v[0] <= r_v1;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_sin   = r_y[CORDIC_STEPS];
    assign o_cos   = r_f[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== design/hvd_isqrt.sv =====
`default_nettype none

module hvd_isqrt import hvd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [SQ_IN_W-1:0]  i_rad,
    output logic                     o_valid,
    output logic [SQ_OUT_W-1:0]      o_root
);

    logic [SQ_IN_W-1:0] r_n    [0:SQ_OUT_W];
    logic [SQ_IN_W-1:0] r_root [0:SQ_OUT_W];
    logic               r_v    [0:SQ_OUT_W];

    // one result bit per stage, largest first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= i_rad;
            r_root[0] <= '0;
            for (int k = 0; k < SQ_OUT_W; k++) begin
                if (r_n[k] >= r_root[k] + sq_bit(k)) begin
                    r_n[k+1]    <= r_n[k] - (r_root[k] + sq_bit(k));
                    r_root[k+1] <= (r_root[k] >> 1) + sq_bit(k);
                end else begin
                    r_n[k+1]    <= r_n[k];
                    r_root[k+1] <= r_root[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ_OUT_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < SQ_OUT_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[SQ_OUT_W];
    assign o_root  = r_root[SQ_OUT_W][SQ_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== design/hvd_atan.sv =====
`default_nettype none

module hvd_atan import hvd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_q                   i_x,
    input  wire t_q                   i_y,
    output logic                      o_valid,
    output logic [ATAN_O_W-1:0]       o_ang
);

    t_q   r_x [0:CORDIC_STEPS];
    t_q   r_y [0:CORDIC_STEPS];
    t_q   r_z [0:CORDIC_STEPS];
    logic r_v [0:CORDIC_STEPS];

    // vectoring: drive y to zero, collect the angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q30(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_ang   = r_z[CORDIC_STEPS][Q_W-1] ? '0 : r_z[CORDIC_STEPS][ATAN_O_W-1:0];

endmodule

`default_nettype wire

// ===== sim/tb_haversine_distance_core.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_haversine_distance_core;
    import hvd_pkg::*;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat_first;
        logic signed [LON_W-1:0] lon_first;
        logic signed [LAT_W-1:0] lat_second;
        logic signed [LON_W-1:0] lon_second;
    } t_point_pair;

    localparam longint ATAN_TBL [CORDIC_STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097141, 1048574, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 8, 4, 2
    };
    localparam longint LAT_LIM = 5898240;
    localparam longint LON_LIM = 11796480;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hvd_in_if  pair_ch ();
    hvd_out_if dist_ch ();

    haversine_distance_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_ch.sink),
        .o_out   (dist_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_point_pair          pending_pairs[$];
    logic [DIST_W-1:0]    expected_dist[$];
    int                   mismatch_cnt = 0;

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint ua, ub, r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r  = (ua * ub + (longint'(1) << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint root, bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // half-angle in 2^-(frac+1) degree to q30 sin and cos
    function automatic void half_sin_cos(input longint ang, output longint s,
                                         output longint c);
        longint r, mag, x, y, z, dx, dy;
        bit     flip;
        r    = ang % TURN;
        flip = 1'b0;
        if (r < 0) r += TURN;
        if (r >= HALF_TURN) r -= TURN;
        if (r > QUARTER_TURN) begin
            r = HALF_TURN - r;
            flip = 1'b1;
        end else if (r < -QUARTER_TURN) begin
            r = -HALF_TURN - r;
            flip = 1'b1;
        end
        mag = ((r < 0) ? -r : r) << NORM_SHIFT;
        z   = (mag * DEG_TO_RAD_Q32 + (longint'(1) << 26)) >>> 27;
        if (r < 0) z = -z;
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_m(input t_point_pair p);
        longint u, v, c1, c2, nu, h, s, w, x, y, z, dx, dy, d;
        half_sin_cos(longint'(p.lat_second) - longint'(p.lat_first), u, nu);
        half_sin_cos(longint'(p.lon_second) - longint'(p.lon_first), v, nu);
        half_sin_cos(longint'(p.lat_first) * 2, nu, c1);
        half_sin_cos(longint'(p.lat_second) * 2, nu, c2);
        h = qmul(u, u) + qmul(qmul(c1, c2), qmul(v, v));
        if (h < 0) h = 0;
        if (h > ONE_Q30) h = ONE_Q30;
        s = int_sqrt(h << 30);
        w = int_sqrt((ONE_Q30 - h) << 30);
        x = w;
        y = s;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        if (z < 0) z = 0;
        d = (z * DIST_SCALE + (longint'(1) << 29)) >>> 30;
        if (d > DIST_MAX) d = DIST_MAX;
        return DIST_W'(d);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint rand_in(input longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic queue_pair(input longint a, input longint b, input longint c,
                              input longint d);
        t_point_pair p;
        p.lat_first  = LAT_W'(a);
        p.lon_first  = LON_W'(b);
        p.lat_second = LAT_W'(c);
        p.lon_second = LON_W'(d);
        pending_pairs.push_back(p);
    endtask

    // driver
    int src_gap = 0;
    bit src_burst = 1'b0;
    bit in_acc = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pair_ch.valid <= 1'b0;
        end else begin
            if (in_acc)
                void'(pending_pairs.pop_front());
            if (pair_ch.valid && !in_acc) begin
                // hold current transaction
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                pair_ch.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                pair_ch.valid      <= 1'b1;
                {pair_ch.lat_first, pair_ch.lon_first,
                 pair_ch.lat_second, pair_ch.lon_second} <= pending_pairs[0];
                if (!src_burst) src_gap <= gap_len();
            end else begin
                pair_ch.valid <= 1'b0;
            end
        end
    end

    // accepted transactions and sink stall
    int snk_gap = 0;
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && pair_ch.valid && pair_ch.ready;
        if (i_rst_n && pair_ch.valid && pair_ch.ready)
            expected_dist.push_back(great_circle_m(
                {pair_ch.lat_first, pair_ch.lon_first, pair_ch.lat_second,
                 pair_ch.lon_second}));
    end

    always @(negedge i_clk) begin
        if (src_burst || snk_gap == 0) begin
            dist_ch.ready <= 1'b1;
            snk_gap <= src_burst ? 0 : gap_len();
        end else begin
            dist_ch.ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] exp_d;
        if (i_rst_n && dist_ch.valid && dist_ch.ready) begin
            if (expected_dist.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected distance transaction: %0d", dist_ch.distance_m);
            end else begin
                exp_d = expected_dist.pop_front();
                if (dist_ch.distance_m !== exp_d) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("distance_m mismatch: expected %0d actual %0d",
                                 exp_d, dist_ch.distance_m);
                end
            end
        end
    end

    initial begin
        pair_ch.valid      = 1'b0;
        pair_ch.lat_first  = '0;
        pair_ch.lon_first  = '0;
        pair_ch.lat_second = '0;
        pair_ch.lon_second = '0;
        dist_ch.ready      = 1'b0;

        // extremes, identical points, antipodes, poles, out-of-range patterns
        queue_pair(0, 0, 0, 0);
        queue_pair(LAT_LIM, LON_LIM, LAT_LIM, LON_LIM);
        queue_pair(0, 0, 0, LON_LIM);
        queue_pair(0, -LON_LIM, 0, LON_LIM);
        queue_pair(LAT_LIM, 0, -LAT_LIM, 0);
        queue_pair(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM);
        queue_pair(LAT_LIM, 123456, LAT_LIM, -654321);
        queue_pair(2949120, 0, -2949120, LON_LIM);
        queue_pair(0, 0, 1, 1);
        queue_pair(-1, -1, 0, 0);
        queue_pair(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1);
        queue_pair((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24));
        queue_pair(-(1 << 23), 0, -(1 << 23), 0);
        queue_pair(8000000, 100, -8000000, -100);
        queue_pair(0, (1 << 24) - 1, 0, -(1 << 24));
        queue_pair(LAT_LIM, 0, LAT_LIM, 1);
        queue_pair(100, 200, 101, 200);
        queue_pair(0, 0, 0, 2 * LON_LIM - 1);
        queue_pair(32768, -LON_LIM, -32768, LON_LIM - 1);
        queue_pair(24'h555555, 25'h0AAAAAA, 24'h2AAAAA, 25'h1555555);

        for (int i = 0; i < 950; i++) begin
            case ($urandom_range(0, 9))
                0: queue_pair($urandom, $urandom, $urandom, $urandom);
                1: begin
                    longint a, b;
                    a = rand_in(LAT_LIM);
                    b = rand_in(LON_LIM);
                    queue_pair(a, b, a + $urandom_range(0, 64) - 32,
                               b + $urandom_range(0, 64) - 32);
                end
                default: queue_pair(rand_in(LAT_LIM), rand_in(LON_LIM),
                                    rand_in(LAT_LIM), rand_in(LON_LIM));
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // back-to-back stretch in the middle of the run
        wait (pending_pairs.size() <= 650);
        src_burst = 1'b1;
        wait (pending_pairs.size() <= 530);
        src_burst = 1'b0;

        wait (pending_pairs.size() == 0 && !pair_ch.valid);
        wait (expected_dist.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_dist.size() == 0)
            $display("tb_haversine_distance_core OK");
        else
            $display("tb_haversine_distance_core NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_haversine_distance_core NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/hvd_pkg.sv
design/hvd_in_if.sv
design/hvd_out_if.sv
design/hvd_sincos.sv
design/hvd_isqrt.sv
design/hvd_atan.sv
design/haversine_distance_core.sv
sim/tb_haversine_distance_core.sv
